// ===== rtl/dlfh_pkg.sv =====
package dlfh_pkg;

	localparam int NUM_DEV    = 6;
	localparam int DEV_W      = 3;
	localparam int ID_BITS    = 8;
	localparam int WAIT_DEPTH = 16;
	localparam int PTR_W      = $clog2(WAIT_DEPTH);
	localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);
	localparam int MEM_DEPTH  = NUM_DEV * WAIT_DEPTH;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [DEV_W-1:0]   dev_t;
	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	typedef struct packed {
		logic granted;
		logic queued;
		logic queue_full;
		logic released;
		logic owner_valid;
		id_t  owner_id;
	} res_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		id_t   data;
	} mem_wr_t;

	function automatic ptr_t next_slot(input ptr_t p);
		return (p == PTR_W'(WAIT_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	function automatic addr_t mem_addr(input dev_t dev, input ptr_t p);
		return addr_t'(addr_t'(dev) * addr_t'(WAIT_DEPTH)) + addr_t'(p);
	endfunction

endpackage

// ===== rtl/dlfh_wait_mem.sv =====
module dlfh_wait_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  dlfh_pkg::mem_wr_t wr,
	input  logic              rd_en,
	input  dlfh_pkg::addr_t   rd_addr,
	output dlfh_pkg::id_t     rd_data
);
	import dlfh_pkg::*;

	id_t  mem [MEM_DEPTH];
	id_t  rd_q;
	id_t  byp_data_q;
	logic byp_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr.data;
		end
	end

	// same-cycle write to the read address wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr.en && (wr.addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

// ===== rtl/dlfh_lock_state.sv =====
module dlfh_lock_state (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              op,
	input  dlfh_pkg::dev_t    dev,
	input  dlfh_pkg::id_t     id,
	input  dlfh_pkg::id_t     head_data,
	input  dlfh_pkg::dev_t    acc_dev,
	output dlfh_pkg::res_t    res,
	output dlfh_pkg::mem_wr_t wr,
	output dlfh_pkg::addr_t   rd_addr
);
	import dlfh_pkg::*;

	logic held_q [NUM_DEV];
	id_t  pid_q  [NUM_DEV];
	ptr_t head_q [NUM_DEV];
	ptr_t tail_q [NUM_DEV];
	cnt_t cnt_q  [NUM_DEV];

	logic dev_ok;
	logic held, n_held;
	id_t  pid, n_pid;
	ptr_t head, n_head, tail, n_tail, rd_head;
	cnt_t cnt, n_cnt;

	assign dev_ok = dev < DEV_W'(NUM_DEV);

	always_comb begin
		held = 1'b0;
		pid  = '0;
		head = '0;
		tail = '0;
		cnt  = '0;
		for (int i = 0; i < NUM_DEV; i++) begin
			if (dev == DEV_W'(i)) begin
				held = held_q[i];
				pid  = pid_q[i];
				head = head_q[i];
				tail = tail_q[i];
				cnt  = cnt_q[i];
			end
		end

		n_held  = held;
		n_pid   = pid;
		n_head  = head;
		n_tail  = tail;
		n_cnt   = cnt;
		res     = '0;
		wr.en   = 1'b0;
		wr.addr = mem_addr(dev, tail);
		wr.data = id;

		if (dev_ok) begin
			if (op == OP_REQUEST) begin
				if (!held || pid == id) begin
					n_held      = 1'b1;
					n_pid       = id;
					res.granted = 1'b1;
				end else if (cnt != CNT_W'(WAIT_DEPTH)) begin
					wr.en      = fire;
					n_tail     = next_slot(tail);
					n_cnt      = cnt_t'(cnt + 1'b1);
					res.queued = 1'b1;
				end else begin
					res.queue_full = 1'b1;
				end
			end else if (held && pid == id) begin
				res.released = 1'b1;
				if (cnt != '0) begin
					n_pid  = head_data;
					n_head = next_slot(head);
					n_cnt  = cnt_t'(cnt - 1'b1);
				end else begin
					n_held = 1'b0;
					n_pid  = '0;
				end
			end
			res.owner_valid = n_held;
			res.owner_id    = n_held ? n_pid : '0;
		end
	end

	// head pointer for the incoming item, seen through this cycle's update
	always_comb begin
		rd_head = '0;
		for (int i = 0; i < NUM_DEV; i++) begin
			if (acc_dev == DEV_W'(i)) begin
				rd_head = head_q[i];
			end
		end
		if (fire && dev_ok && acc_dev == dev) begin
			rd_head = n_head;
		end
		rd_addr = mem_addr(acc_dev, rd_head);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DEV; i++) begin
				held_q[i] <= 1'b0;
				pid_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (fire && dev_ok) begin
			for (int i = 0; i < NUM_DEV; i++) begin
				if (dev == DEV_W'(i)) begin
					held_q[i] <= n_held;
					pid_q[i]  <= n_pid;
					head_q[i] <= n_head;
					tail_q[i] <= n_tail;
					cnt_q[i]  <= n_cnt;
				end
			end
		end
	end

endmodule

// ===== rtl/device_lock_fifo_handoff_top.sv =====
// Six device locks (modem, scanner, printer 1/2, disk 1/2), each with an owner
// and a 16-deep FIFO of waiters. One request or release transfer is taken per
// cycle unless the result stalls; the result is registered after the input
// register, which also launches the read of the queue head from the shared
// 96-entry wait memory (one write, one read per cycle); lock update and result
// register follow. Resource codes 6 and 7 return an all-zero result. The wait
// memory needs no clearing after reset, so the block takes input right away.
module device_lock_fifo_handoff_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  logic           operation,
	input  dlfh_pkg::dev_t resource,
	input  dlfh_pkg::id_t  requester_id,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output logic           granted,
	output logic           queued,
	output logic           queue_full,
	output logic           released,
	output logic           owner_valid,
	output dlfh_pkg::id_t  owner_id
);
	import dlfh_pkg::*;

	logic    valid_s1, valid_s2;
	logic    op_s1;
	dev_t    dev_s1;
	id_t     id_s1;
	res_t    res, res_s2;
	mem_wr_t wr;
	addr_t   rd_addr;
	id_t     head_data;
	logic    fire, acc;

	assign fire      = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !fire;
	assign acc       = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1  <= operation;
			dev_s1 <= resource;
			id_s1  <= requester_id;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	dlfh_lock_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.op        (op_s1),
		.dev       (dev_s1),
		.id        (id_s1),
		.head_data (head_data),
		.acc_dev   (resource),
		.res       (res),
		.wr        (wr),
		.rd_addr   (rd_addr)
	);

	dlfh_wait_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (acc),
		.rd_addr (rd_addr),
		.rd_data (head_data)
	);

	assign rsp_valid   = valid_s2;
	assign granted     = res_s2.granted;
	assign queued      = res_s2.queued;
	assign queue_full  = res_s2.queue_full;
	assign released    = res_s2.released;
	assign owner_valid = res_s2.owner_valid;
	assign owner_id    = res_s2.owner_id;

endmodule

// ===== rtl/dlfh_checker.sv =====
module dlfh_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input logic          granted,
	input logic          queued,
	input logic          queue_full,
	input logic          released,
	input logic          owner_valid,
	input dlfh_pkg::id_t owner_id
);
	import dlfh_pkg::*;

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({granted, queued, queue_full, released}))
		else $error("more than one outcome flag set");

	a_free_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !owner_valid |-> owner_id == '0)
		else $error("free device reports nonzero owner");

	a_request_owned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (granted || queued || queue_full) |-> owner_valid)
		else $error("request outcome with no owner");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable({granted, queued, queue_full,
			released, owner_valid, owner_id}))
		else $error("stalled result changed");

endmodule

bind device_lock_fifo_handoff_top dlfh_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.granted     (granted),
	.queued      (queued),
	.queue_full  (queue_full),
	.released    (released),
	.owner_valid (owner_valid),
	.owner_id    (owner_id)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import dlfh_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic operation = OP_REQUEST;
	dev_t resource = '0;
	id_t requester_id = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic granted;
	logic queued;
	logic queue_full;
	logic released;
	logic owner_valid;
	id_t owner_id;

	device_lock_fifo_handoff_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.operation(operation),
		.resource(resource),
		.requester_id(requester_id),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.granted(granted),
		.queued(queued),
		.queue_full(queue_full),
		.released(released),
		.owner_valid(owner_valid),
		.owner_id(owner_id)
	);

	// lock state mirror
	logic lock_held[NUM_DEV];
	id_t lock_owner[NUM_DEV];
	id_t waiter_ring[NUM_DEV][WAIT_DEPTH];
	int waiter_head[NUM_DEV];
	int waiter_count[NUM_DEV];

	res_t pending_outcomes[$];
	int error_count = 0;
	int reported = 0;
	int cycle_count = 0;
	int burst_left = 0;
	logic gaps_on = 1'b1;
	int stall_run = 0;
	int stall_mode = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic res_t lock_outcome(input logic op, input dev_t dev, input id_t id);
		res_t r;
		int d;
		r = '0;
		if (dev >= NUM_DEV)
			return r;
		d = dev;
		if (op == OP_REQUEST) begin
			if (!lock_held[d] || lock_owner[d] == id) begin
				lock_held[d] = 1'b1;
				lock_owner[d] = id;
				r.granted = 1'b1;
			end else if (waiter_count[d] < WAIT_DEPTH) begin
				waiter_ring[d][(waiter_head[d] + waiter_count[d]) % WAIT_DEPTH] = id;
				waiter_count[d]++;
				r.queued = 1'b1;
			end else begin
				r.queue_full = 1'b1;
			end
		end else if (lock_held[d] && lock_owner[d] == id) begin
			r.released = 1'b1;
			if (waiter_count[d] > 0) begin
				lock_owner[d] = waiter_ring[d][waiter_head[d]];
				waiter_head[d] = (waiter_head[d] + 1) % WAIT_DEPTH;
				waiter_count[d]--;
			end else begin
				lock_held[d] = 1'b0;
				lock_owner[d] = '0;
			end
		end
		r.owner_valid = lock_held[d];
		r.owner_id = lock_held[d] ? lock_owner[d] : id_t'(0);
		return r;
	endfunction

	// called and returns just after a falling edge
	task automatic issue_op(input logic op, input dev_t dev, input id_t id);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				req_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_valid = 1'b1;
		operation = op;
		resource = dev;
		requester_id = id;
		do @(posedge clk); while (req_stall);
		pending_outcomes.push_back(lock_outcome(op, dev, id));
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		req_valid = 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_modem_handoff();
		issue_op(OP_REQUEST, 3'd0, 8'h00);
		issue_op(OP_REQUEST, 3'd0, 8'hFF);
		issue_op(OP_REQUEST, 3'd0, 8'hFF);
		issue_op(OP_REQUEST, 3'd0, 8'h00);
		issue_op(OP_RELEASE, 3'd0, 8'hFF);
		issue_op(OP_RELEASE, 3'd0, 8'h00);
		issue_op(OP_RELEASE, 3'd0, 8'hFF);
		issue_op(OP_RELEASE, 3'd0, 8'hFF);
		issue_op(OP_RELEASE, 3'd0, 8'h00);
	endtask

	task automatic test_invalid_resource();
		issue_op(OP_REQUEST, 3'd6, 8'hFF);
		issue_op(OP_RELEASE, 3'd6, 8'h00);
		issue_op(OP_REQUEST, 3'd7, 8'h00);
		issue_op(OP_RELEASE, 3'd7, 8'hFF);
	endtask

	task automatic test_each_device();
		int d;
		for (d = 1; d < NUM_DEV; d++)
			issue_op(OP_REQUEST, dev_t'(d), (d % 2) ? 8'hAA : 8'h55);
		for (d = 1; d < NUM_DEV; d++)
			issue_op(OP_RELEASE, dev_t'(d), (d % 2) ? 8'hAA : 8'h55);
	endtask

	task automatic test_queue_full();
		int d;
		int k;
		id_t id;
		d = $urandom_range(0, NUM_DEV - 1);
		issue_op(OP_REQUEST, dev_t'(d), lock_held[d] ? lock_owner[d] : id_t'($urandom));
		for (k = 0; k < WAIT_DEPTH + 3; k++) begin
			id = id_t'($urandom);
			if (id == lock_owner[d])
				id = id ^ 8'h01;
			issue_op(OP_REQUEST, dev_t'(d), id);
		end
		while (lock_held[d])
			issue_op(OP_RELEASE, dev_t'(d), lock_owner[d]);
	endtask

	task automatic test_random_traffic(input int n);
		int i;
		int k;
		int req_pct;
		int focus;
		int pick;
		logic op;
		dev_t dev;
		id_t id;
		id_t pool[8];
		req_pct = 50;
		focus = 0;
		for (i = 0; i < n; i++) begin
			if (i % 100 == 0) begin
				if (i > 0)
					wait_all_results();
				req_pct = $urandom_range(35, 80);
				focus = $urandom_range(0, NUM_DEV - 1);
				for (k = 0; k < 8; k++)
					pool[k] = id_t'($urandom);
				gaps_on = ((i / 100) % 3 != 2);
			end
			pick = $urandom_range(0, 99);
			if (pick < 5)
				dev = dev_t'($urandom_range(NUM_DEV, 7));
			else if (pick < 45)
				dev = dev_t'(focus);
			else
				dev = dev_t'($urandom_range(0, NUM_DEV - 1));
			op = ($urandom_range(0, 99) < req_pct) ? OP_REQUEST : OP_RELEASE;
			if (op == OP_RELEASE && dev < NUM_DEV && lock_held[dev] &&
					$urandom_range(0, 9) < 7)
				id = lock_owner[dev];
			else if ($urandom_range(0, 99) < 85)
				id = pool[$urandom_range(0, 7)];
			else
				id = id_t'($urandom);
			issue_op(op, dev, id);
		end
		gaps_on = 1'b1;
	endtask

	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run = $urandom_range(5, 40);
		end
		stall_run--;
		case (stall_mode)
			0: rsp_stall = 1'b0;
			1: rsp_stall = ($urandom_range(0, 3) == 0);
			2: rsp_stall = ($urandom_range(0, 1) == 1);
			default: rsp_stall = (stall_run % 8 < 5);
		endcase
	end

	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = {granted, queued, queue_full, released, owner_valid, owner_id};
			if (pending_outcomes.size() == 0) begin
				error_count++;
				if (reported < 10) begin
					reported++;
					$display("unexpected transfer: g%0b q%0b f%0b r%0b v%0b id %0h",
						got.granted, got.queued, got.queue_full, got.released,
						got.owner_valid, got.owner_id);
				end
			end else begin
				want = pending_outcomes.pop_front();
				if (got !== want) begin
					error_count++;
					if (reported < 10) begin
						reported++;
						$write("mismatch: expected g%0b q%0b f%0b r%0b v%0b id %0h,",
							want.granted, want.queued, want.queue_full, want.released,
							want.owner_valid, want.owner_id);
						$display(" got g%0b q%0b f%0b r%0b v%0b id %0h",
							got.granted, got.queued, got.queue_full, got.released,
							got.owner_valid, got.owner_id);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		int d;
		for (d = 0; d < NUM_DEV; d++) begin
			lock_held[d] = 1'b0;
			lock_owner[d] = '0;
			waiter_head[d] = 0;
			waiter_count[d] = 0;
		end
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_modem_handoff();
		test_invalid_resource();
		test_each_device();
		wait_all_results();
		test_queue_full();
		wait_all_results();
		test_random_traffic(600);
		wait_all_results();
		repeat (10) @(negedge clk);

		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
